// ===== src/prm_pkg.sv =====
// Shared constants, register indexes and control/status types for the
// Z_n[x]/(m(x)) arithmetic unit. No dependencies.
package prm_pkg;

  localparam int COEFFS_DEF    = 8;
  localparam int COEF_BITS_DEF = 8;
  localparam int WORD_W        = 64;
  localparam int MOD_W         = 9;
  localparam int DEG_W         = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int DIV_STEPS     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_POLY = 1'b1;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_MULMOD = 1'b1;

  localparam logic [MOD_W-1:0]  COEF_MODULUS_RST = 9'd2;
  localparam logic [WORD_W-1:0] MODULUS_POLY_RST = 64'h0000_0000_0001_0101;

  typedef enum logic [2:0] {
    SRC_ADD,
    SRC_MAC,
    SRC_NLEAD,
    SRC_TOP,
    SRC_SUB
  } src_t;

  typedef struct packed {
    logic load;
    logic div_go;
    src_t src;
    logic take;
    logic next_lane;
    logic next_pair;
    logic start_reduce;
    logic next_term;
    logic next_step;
    logic search;
    logic set_err;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic op_mul;
    logic div_done;
    logic last_lane;
    logic last_pair;
    logic last_term;
    logic last_step;
    logic found;
    logic exhausted;
    logic m_zero;
    logic below;
  } stat_t;

endpackage

// ===== src/prm_div.sv =====
// Multi-cycle restoring divider: quotient and remainder, DIV_STEPS bits per cycle.
// Depends on prm_pkg.
module prm_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);
  import prm_pkg::*;

  localparam int PASSES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int SH_W   = PASSES * DIV_STEPS;
  localparam int RW     = DEN_W + 1;
  localparam int CW     = $clog2(PASSES + 1);

  logic [SH_W-1:0]  sh, sh_next;
  logic [RW-1:0]    rm, rm_next;
  logic [DEN_W-1:0] dv;
  logic [CW-1:0]    cnt;

  assign busy = cnt != '0;
  assign quot = sh[NUM_W-1:0];
  assign rem  = rm[DEN_W-1:0];

  always_comb begin
    sh_next = sh;
    rm_next = rm;
    for (int s = 0; s < DIV_STEPS; s++) begin
      rm_next = {rm_next[RW-2:0], sh_next[SH_W-1]};
      sh_next = {sh_next[SH_W-2:0], 1'b0};
      if (rm_next >= RW'(dv)) begin
        rm_next    = rm_next - RW'(dv);
        sh_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (go) begin
      cnt <= CW'(PASSES);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh <= SH_W'(num);
      rm <= '0;
      dv <= den;
    end else if (busy) begin
      sh <= sh_next;
      rm <= rm_next;
    end
  end

endmodule

// ===== src/prm_dp.sv =====
// Datapath: operand lanes, product/remainder array, address counters, digit
// search and result registers. Depends on prm_pkg and prm_div.
module prm_dp #(
  parameter int COEFFS    = prm_pkg::COEFFS_DEF,
  parameter int COEF_BITS = prm_pkg::COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  prm_pkg::cmd_t               cmd,
  output prm_pkg::stat_t              stat,
  input  logic [COEF_BITS:0]          n,
  input  logic [prm_pkg::WORD_W-1:0]  modulus_poly,
  input  logic                        operation,
  input  logic [prm_pkg::WORD_W-1:0]  operand_a,
  input  logic [prm_pkg::WORD_W-1:0]  operand_b,
  output logic [prm_pkg::WORD_W-1:0]  result_poly,
  output logic [prm_pkg::DEG_W-1:0]   result_degree,
  output logic                        no_digit_error
);
  import prm_pkg::*;

  localparam int CB = COEF_BITS;
  localparam int NW = CB + 1;
  localparam int LW = $clog2(COEFFS);
  localparam int PL = 2 * COEFFS - 1;
  localparam int PW = $clog2(PL);
  localparam int VW = 2 * CB + 1;

  logic [CB-1:0] a_l [COEFFS];
  logic [CB-1:0] b_l [COEFFS];
  logic [CB-1:0] m_l [COEFFS];
  logic [CB-1:0] res [PL];

  logic [LW-1:0] ai, bj, jj, mdeg, midx;
  logic [PW-1:0] t, pdeg, addr;
  logic [CB-1:0] k, rn, r, lead, res_rd, d_rem, r_step, sub_val;
  logic [NW-1:0] qn, q, q_step, d_quot, den, rs, rs_red, sub_tmp;
  logic [NW-1:0] d_rem_full;
  logic [VW-1:0] num, d_quot_full;
  logic [2*CB-1:0] prod_ab, prod_qm;
  logic [DEG_W-1:0] odeg;
  logic [WORD_W-1:0] packed_res;
  logic op_mul, err, m_zero, wrap, div_busy;
  src_t src_q, src_sel;

  always_comb begin
    for (int i = 0; i < COEFFS; i++) begin
      m_l[i] = modulus_poly[i*CB +: CB];
    end
  end

  always_comb begin
    mdeg   = '0;
    m_zero = 1'b1;
    for (int i = 0; i < COEFFS; i++) begin
      if (m_l[i] != '0) begin
        mdeg   = LW'(i);
        m_zero = 1'b0;
      end
    end
  end

  always_comb begin
    pdeg = '0;
    for (int i = 0; i < PL; i++) begin
      if (res[i] != '0) begin
        pdeg = PW'(i);
      end
    end
  end

  always_comb begin
    odeg       = '0;
    packed_res = '0;
    for (int i = 0; i < COEFFS; i++) begin
      packed_res[i*CB +: CB] = res[i];
      if (res[i] != '0) begin
        odeg = DEG_W'(i);
      end
    end
  end

  assign lead    = m_l[mdeg];
  assign midx    = mdeg - jj;
  assign src_sel = cmd.div_go ? cmd.src : src_q;

  always_comb begin
    case (src_sel)
      SRC_ADD: addr = PW'(ai);
      SRC_MAC: addr = PW'(ai) + PW'(bj);
      default: addr = t - PW'(jj);
    endcase
  end

  assign res_rd  = res[addr];
  assign prod_ab = {{CB{1'b0}}, a_l[ai]} * {{CB{1'b0}}, b_l[bj]};
  assign prod_qm = {{CB{1'b0}}, q[CB-1:0]} * {{CB{1'b0}}, m_l[midx]};

  always_comb begin
    case (cmd.src)
      SRC_ADD: begin
        num = VW'(a_l[ai]) + VW'(b_l[ai]);
        den = n;
      end
      SRC_MAC: begin
        num = VW'(res_rd) + VW'(prod_ab);
        den = n;
      end
      SRC_NLEAD: begin
        num = VW'(n);
        den = NW'(lead);
      end
      SRC_TOP: begin
        num = VW'(res_rd);
        den = NW'(lead);
      end
      SRC_SUB: begin
        num = VW'(prod_qm);
        den = n;
      end
      default: begin
        num = '0;
        den = n;
      end
    endcase
  end

  prm_div #(
    .NUM_W(VW),
    .DEN_W(NW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (num),
    .den  (den),
    .busy (div_busy),
    .quot (d_quot_full),
    .rem  (d_rem_full)
  );

  assign d_quot = d_quot_full[NW-1:0];
  assign d_rem  = d_rem_full[CB-1:0];

  assign sub_tmp = (res_rd >= d_rem) ? NW'(res_rd) - NW'(d_rem)
                                     : NW'(res_rd) + n - NW'(d_rem);
  assign sub_val = sub_tmp[CB-1:0];

  assign rs     = NW'(r) + NW'(rn);
  assign wrap   = rs >= NW'(lead);
  assign rs_red = rs - NW'(lead);
  assign r_step = wrap ? rs_red[CB-1:0] : rs[CB-1:0];
  assign q_step = q + qn + NW'(wrap);

  always_comb begin
    stat.op_mul    = op_mul;
    stat.div_done  = !div_busy;
    stat.last_lane = ai == LW'(COEFFS - 1);
    stat.last_pair = (ai == LW'(COEFFS - 1)) && (bj == LW'(COEFFS - 1));
    stat.last_term = jj == mdeg;
    stat.last_step = t == PW'(mdeg);
    stat.found     = r == '0;
    stat.exhausted = k == lead - 1'b1;
    stat.m_zero    = m_zero;
    stat.below     = pdeg < PW'(mdeg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ai    <= '0;
      bj    <= '0;
      t     <= '0;
      jj    <= '0;
      k     <= '0;
      err   <= 1'b0;
      src_q <= SRC_ADD;
    end else begin
      if (cmd.load) begin
        ai  <= '0;
        bj  <= '0;
        err <= 1'b0;
      end
      if (cmd.div_go) begin
        src_q <= cmd.src;
      end
      if (cmd.next_lane) begin
        ai <= ai + 1'b1;
      end
      if (cmd.next_pair) begin
        if (bj == LW'(COEFFS - 1)) begin
          bj <= '0;
          ai <= ai + 1'b1;
        end else begin
          bj <= bj + 1'b1;
        end
      end
      if (cmd.start_reduce) begin
        t  <= pdeg;
        jj <= '0;
      end
      if (cmd.next_term) begin
        jj <= jj + 1'b1;
      end
      if (cmd.next_step) begin
        t  <= t - 1'b1;
        jj <= '0;
      end
      if (cmd.take && src_q == SRC_TOP) begin
        k <= '0;
      end else if (cmd.search) begin
        k <= k + 1'b1;
      end
      if (cmd.set_err) begin
        err <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mul <= operation == OP_MULMOD;
      for (int i = 0; i < COEFFS; i++) begin
        a_l[i] <= operand_a[i*CB +: CB];
        b_l[i] <= operand_b[i*CB +: CB];
      end
      for (int i = 0; i < PL; i++) begin
        res[i] <= '0;
      end
    end else if (cmd.take) begin
      case (src_q)
        SRC_ADD, SRC_MAC: res[addr] <= d_rem;
        SRC_SUB: res[addr] <= sub_val;
        SRC_NLEAD: begin
          qn <= d_quot;
          rn <= d_rem;
        end
        SRC_TOP: begin
          q <= d_quot;
          r <= d_rem;
        end
        default: ;
      endcase
    end else if (cmd.search) begin
      q <= q_step;
      r <= r_step;
    end
    if (cmd.capture) begin
      if (err) begin
        result_poly    <= '0;
        result_degree  <= '0;
        no_digit_error <= 1'b1;
      end else begin
        result_poly    <= packed_res;
        result_degree  <= odeg;
        no_digit_error <= 1'b0;
      end
    end
  end

endmodule

// ===== src/prm_ctrl.sv =====
// Controller: sequences add, multiply-accumulate and long division steps
// over the datapath, and owns the channel handshakes. Depends on prm_pkg.
module prm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  prm_pkg::stat_t stat,
  output prm_pkg::cmd_t  cmd
);
  import prm_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    START,
    ADD_GO,
    ADD_WAIT,
    MUL_GO,
    MUL_WAIT,
    RED_CHK,
    NL_GO,
    NL_WAIT,
    TOP_GO,
    TOP_WAIT,
    SEARCH,
    SUB_GO,
    SUB_WAIT,
    FINISH
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = state == IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = START;
        end
      end
      START: state_next = stat.op_mul ? MUL_GO : ADD_GO;
      ADD_GO: begin
        cmd.div_go = 1'b1;
        cmd.src    = SRC_ADD;
        state_next = ADD_WAIT;
      end
      ADD_WAIT: begin
        if (stat.div_done) begin
          cmd.take = 1'b1;
          if (stat.last_lane) begin
            state_next = FINISH;
          end else begin
            cmd.next_lane = 1'b1;
            state_next    = ADD_GO;
          end
        end
      end
      MUL_GO: begin
        cmd.div_go = 1'b1;
        cmd.src    = SRC_MAC;
        state_next = MUL_WAIT;
      end
      MUL_WAIT: begin
        if (stat.div_done) begin
          cmd.take = 1'b1;
          if (stat.last_pair) begin
            state_next = RED_CHK;
          end else begin
            cmd.next_pair = 1'b1;
            state_next    = MUL_GO;
          end
        end
      end
      RED_CHK: begin
        if (stat.m_zero) begin
          cmd.set_err = 1'b1;
          state_next  = FINISH;
        end else if (stat.below) begin
          state_next = FINISH;
        end else begin
          cmd.start_reduce = 1'b1;
          state_next       = NL_GO;
        end
      end
      NL_GO: begin
        cmd.div_go = 1'b1;
        cmd.src    = SRC_NLEAD;
        state_next = NL_WAIT;
      end
      NL_WAIT: begin
        if (stat.div_done) begin
          cmd.take   = 1'b1;
          state_next = TOP_GO;
        end
      end
      TOP_GO: begin
        cmd.div_go = 1'b1;
        cmd.src    = SRC_TOP;
        state_next = TOP_WAIT;
      end
      TOP_WAIT: begin
        if (stat.div_done) begin
          cmd.take   = 1'b1;
          state_next = SEARCH;
        end
      end
      SEARCH: begin
        if (stat.found) begin
          state_next = SUB_GO;
        end else if (stat.exhausted) begin
          cmd.set_err = 1'b1;
          state_next  = FINISH;
        end else begin
          cmd.search = 1'b1;
        end
      end
      SUB_GO: begin
        cmd.div_go = 1'b1;
        cmd.src    = SRC_SUB;
        state_next = SUB_WAIT;
      end
      SUB_WAIT: begin
        if (stat.div_done) begin
          cmd.take = 1'b1;
          if (!stat.last_term) begin
            cmd.next_term = 1'b1;
            state_next    = SUB_GO;
          end else if (stat.last_step) begin
            state_next = FINISH;
          end else begin
            cmd.next_step = 1'b1;
            state_next    = TOP_GO;
          end
        end
      end
      FINISH: begin
        if (out_free) begin
          cmd.capture = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> stat.div_done)
    else $error("divider restarted while busy");

  a_take_done: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (stat.div_done && !cmd.div_go))
    else $error("divider result taken before completion");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_capture_out: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> out_valid)
    else $error("captured result not presented");

endmodule

// ===== src/poly_ring_mulmod_zn_unit.sv =====
// Top level of the Z_n[x]/(m(x)) add / multiply-reduce unit: configuration
// registers, controller and datapath. Depends on prm_pkg, prm_ctrl, prm_dp.
//
//   channel  handshake               payload
//   cfg      cfg_wr_en               cfg_index, cfg_data
//   in       in_valid / in_ready     operation, operand_a, operand_b
//   out      out_valid / out_ready   result_poly, result_degree, no_digit_error
//
// Each coefficient operation is one pass of a single shared divider, with an issue state
// before it and a write-back when it is done. Add makes one pass per lane; multiply one
// pass per coefficient pair, then one for n / lead and, per reduction digit, one for the
// top coefficient, a digit search of up to lead candidates and deg m + 1 subtract passes.
// One item in flight; in_ready is high only when idle. A result waits in the output
// register and the next one holds until that register frees. Reset is synchronous.
module poly_ring_mulmod_zn_unit #(
  parameter int COEFFS    = prm_pkg::COEFFS_DEF,
  parameter int COEF_BITS = prm_pkg::COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [prm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prm_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [prm_pkg::WORD_W-1:0]    operand_a,
  input  logic [prm_pkg::WORD_W-1:0]    operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prm_pkg::WORD_W-1:0]    result_poly,
  output logic [prm_pkg::DEG_W-1:0]     result_degree,
  output logic                          no_digit_error
);
  import prm_pkg::*;

  localparam int NW = COEF_BITS + 1;
  localparam logic [MOD_W-1:0] N_MAX = MOD_W'(1 << COEF_BITS);
  localparam logic [MOD_W-1:0] N_MIN = MOD_W'(2);

  logic [MOD_W-1:0]  coef_modulus, n_eff;
  logic [WORD_W-1:0] modulus_poly;
  cmd_t              cmd;
  stat_t             stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_modulus <= COEF_MODULUS_RST;
      modulus_poly <= MODULUS_POLY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_MODULUS: coef_modulus <= cfg_data[MOD_W-1:0];
        REG_MODULUS_POLY: modulus_poly <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (coef_modulus < N_MIN) begin
      n_eff = N_MIN;
    end else if (coef_modulus > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = coef_modulus;
    end
  end

  prm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  prm_dp #(
    .COEFFS    (COEFFS),
    .COEF_BITS (COEF_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .n              (n_eff[NW-1:0]),
    .modulus_poly   (modulus_poly),
    .operation      (operation),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .result_poly    (result_poly),
    .result_degree  (result_degree),
    .no_digit_error (no_digit_error)
  );

endmodule
